// ===== hw/rtl/kmd_pkg.sv =====
// Shared types, constants and a helper function of the key matrix debouncer.
package kmd_pkg;

   localparam int ROWS_DEFAULT = 4;
   localparam int COLS_DEFAULT = 12;

   localparam int ROW_INDEX_W = 2;
   localparam int COL_W       = 12;
   localparam int PASSES_W    = 8;
   localparam int KEY_COUNT_W = 6;
   localparam int ROW_COUNT_W = $clog2(COL_W + 1);

   localparam logic [PASSES_W-1:0] PASSES_RESET = 8'd5;

   typedef struct packed {
      logic [ROW_INDEX_W-1:0] row_index;
      logic [COL_W-1:0]       col_pins_n;
   } req_item_type;

   typedef struct packed {
      logic [COL_W-1:0]       stable_row;
      logic                   settled;
      logic                   bounce_seen;
      logic [KEY_COUNT_W-1:0] key_count;
   } rsp_item_type;

   // Number of set bits in one row sample.
   function automatic logic [ROW_COUNT_W-1:0] row_popcount(input logic [COL_W-1:0] bits);
      logic [ROW_COUNT_W-1:0] total;
      total = '0;
      for (int i = 0; i < COL_W; i++) begin
         total = total + ROW_COUNT_W'(bits[i]);
      end
      return total;
   endfunction

endpackage

// ===== hw/rtl/key_matrix_debouncer.sv =====
// Top level of the key matrix debouncer: input and result registers around the core.
//
// Usage: a scan sequencer presents one scanned row per item on the req_ channel
// (row index plus active-low column pins). An item is taken at a rising edge with
// req_valid high and req_stall low. Every item yields exactly one result item on
// the rsp_ channel: the debounced row for that index, a settled flag, a flag for
// a change seen while still bouncing, and the count of pressed keys.
// The item sits in the input register while the compare, countdown and copy logic
// fills the result register, which then raises rsp_valid; while a full result
// register is stalled, the item waits in the input register.
// Throughput is one item per cycle while rsp_stall stays low; rows may follow
// each other in every cycle, since the stored samples and the countdown update
// in the same cycle that produces the result, so the next row already sees them.
// When the receiver raises rsp_stall, the result register holds its item and the
// input register can still take one more item; only when both are full does
// req_stall rise, in the same cycle as rsp_stall.
// The user must write the debounce pass count through csr_write_enable and
// csr_write_data only while no item is in flight; the block does not enforce it.
// Reset is synchronous and active high; it clears all samples and the stable
// matrix, loads the pass count and countdown with five, and empties both registers.
module key_matrix_debouncer
   import kmd_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_item_type        req_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_item_type        rsp_item,
   input  logic                csr_write_enable,
   input  logic [PASSES_W-1:0] csr_write_data
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   logic         out_free;
   logic         step_fire;
   logic         req_accept;
   rsp_item_type step_result;

   // The result register frees up when it is empty or being taken this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step_fire  = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (step_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load only on their handshake and need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (step_fire) begin
         rsp_item_ff <= step_result;
      end
   end

   kmd_debounce_core #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .step_fire        (step_fire),
      .step_item        (in_item_ff),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step_result      (step_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== hw/rtl/kmd_debounce_core.sv =====
// Row sample store, shared settle countdown, stable matrix and key count.
module kmd_debounce_core
   import kmd_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_fire,
   input  req_item_type        step_item,
   input  logic                csr_write_enable,
   input  logic [PASSES_W-1:0] csr_write_data,
   output rsp_item_type        step_result
);

   localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [COL_W-1:0] ColMask =
      (COLS >= COL_W) ? {COL_W{1'b1}} : COL_W'((64'd1 << COLS) - 64'd1);

   logic [PASSES_W-1:0]    passes_ff;
   logic [PASSES_W-1:0]    countdown_ff, countdown_in;
   logic [COL_W-1:0]       sampled_ff [ROWS];
   logic [COL_W-1:0]       stable_ff  [ROWS];
   logic [ROW_COUNT_W-1:0] row_count_ff [ROWS];
   logic [ROW_COUNT_W-1:0] row_count_in [ROWS];
   logic [KEY_COUNT_W-1:0] key_count_ff, key_count_in;

   logic                   row_ok;
   logic [RowW-1:0]        idx;
   logic [COL_W-1:0]       sample;
   logic                   changed;
   logic                   pass_end;
   logic [PASSES_W-1:0]    reload;
   logic [PASSES_W-1:0]    count_mid;
   logic                   decrement;
   logic                   copy;
   logic [KEY_COUNT_W-1:0] count_sum;

   always_comb begin
      row_ok    = (int'(step_item.row_index) < ROWS);
      idx       = RowW'(step_item.row_index);
      sample    = ~step_item.col_pins_n & ColMask;
      changed   = row_ok && (sampled_ff[idx] != sample);
      pass_end  = row_ok && (int'(step_item.row_index) == ROWS - 1);
      // A zero setting acts as a setting of one, so the copy still waits for a pass end.
      reload    = (passes_ff != '0) ? passes_ff : PASSES_W'(1);
      count_mid = changed ? reload : countdown_ff;
      decrement = pass_end && (count_mid != '0);
      countdown_in = decrement ? count_mid - PASSES_W'(1) : count_mid;
      copy      = decrement && (countdown_in == '0);

      count_sum = '0;
      for (int r = 0; r < ROWS; r++) begin
         row_count_in[r] = (changed && (r == int'(idx))) ? row_popcount(sample)
                                                          : row_count_ff[r];
         count_sum = count_sum + KEY_COUNT_W'(row_count_in[r]);
      end
      key_count_in = copy ? count_sum : key_count_ff;

      step_result.stable_row  = !row_ok ? '0 : (copy ? sample : stable_ff[idx]);
      step_result.settled     = (countdown_in == '0);
      step_result.bounce_seen = changed && (countdown_ff != '0);
      step_result.key_count   = key_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         passes_ff    <= PASSES_RESET;
         countdown_ff <= PASSES_RESET;
         key_count_ff <= '0;
         for (int r = 0; r < ROWS; r++) begin
            sampled_ff[r]   <= '0;
            stable_ff[r]    <= '0;
            row_count_ff[r] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            passes_ff <= csr_write_data;
         end
         if (step_fire) begin
            countdown_ff <= countdown_in;
            key_count_ff <= key_count_in;
            for (int r = 0; r < ROWS; r++) begin
               row_count_ff[r] <= row_count_in[r];
            end
            if (changed) begin
               sampled_ff[idx] <= sample;
            end
            if (copy) begin
               for (int r = 0; r < ROWS; r++) begin
                  stable_ff[r] <= (r == int'(idx)) ? sample : sampled_ff[r];
               end
            end
         end
      end
   end

   // A change outside the pass end leaves the countdown running.
   assert property (@(posedge clock) disable iff (reset)
      step_fire && changed && !pass_end |=> countdown_ff != '0)
      else $error("countdown is zero right after a reload");

   // A copy leaves the matrix settled and the key count of the samples.
   assert property (@(posedge clock) disable iff (reset)
      step_fire && copy |=> countdown_ff == '0 && key_count_ff == $past(count_sum))
      else $error("copy did not settle the matrix or the key count");

   // Without a step the countdown and key count hold.
   assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> $stable(countdown_ff) && $stable(key_count_ff))
      else $error("debounce state moved without a step");

   // The key count never exceeds the size of the matrix.
   assert property (@(posedge clock) disable iff (reset)
      int'(key_count_ff) <= ROWS * COL_W)
      else $error("key count beyond matrix size");

endmodule
